@@ rtl/skq_pkg.sv @@
// Shared types for the sorted key queue.
// Holds the operation codes and the key compare result; no dependencies.
`default_nettype none
package skq_pkg;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_FIND_EQ = 3'd1,
    OP_FIND_LT = 3'd2,
    OP_FIND_GT = 3'd3,
    OP_BY_POS = 3'd4
  } op_e;

  typedef struct packed {
    logic lt;
    logic eq;
    logic gt;
  } cmp_t;

endpackage
`default_nettype wire

@@ rtl/sorted_key_queue_top.sv @@
// Sorted key queue top: sequencer around one entry RAM and a key comparator.
// Depends on skq_pkg, skq_ram and skq_cmp.
//
// Entries are kept in ascending key order in a RAM with registered read;
// the sequencer walks it one entry at a time, a read state before each
// check or write. An insert scans to the insert position, shifts the entries
// from there to the end up by one, last first, and writes the new entry; a
// lookup scans to the hit, to a greater key for an equal-key lookup, or to
// the end; a removal then shifts the later entries down by one; a position
// lookup reads its one entry. A refused insert, a position not below the
// count or an unknown operation goes straight to the result. The sequencer
// then returns to idle, where the next beat is taken. A new beat is taken
// while the previous result still waits on the master side; a finished
// result holds the sequencer until that beat leaves.
`default_nettype none
module sorted_key_queue_top #(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 32,
  parameter int PAYLOAD_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // key[31:0], payload[63:32], position[67:64], zero fill
  input  wire logic [71:0] s_axis_tdata,
  // operation[2:0], remove[3]
  input  wire logic [3:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // found_key[31:0], found_payload[63:32], entry_count[68:64], zero fill
  output logic [71:0]      m_axis_tdata,
  // found[0], rejected[1]
  output logic [1:0]       m_axis_tuser
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = (CW > 4) ? CW : 4;
  localparam int EW = KEY_BITS + PAYLOAD_BITS;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN_RD, ST_SCAN_CK, ST_SHIFT_RD, ST_SHIFT_WR, ST_PUT,
    ST_FETCH_RD, ST_FETCH_CK, ST_DEL_RD, ST_DEL_WR, ST_DONE
  } state_e;

  state_e                  state_q;
  logic                    signed_q;
  logic [CW-1:0]           cnt_q, idx_q, at_q;
  logic [2:0]              op_q;
  logic                    rem_q;
  logic [KEY_BITS-1:0]     key_q, res_key_q;
  logic [PAYLOAD_BITS-1:0] pay_q, res_pay_q;
  logic                    res_found_q, res_rej_q;
  logic                    out_valid_q;
  logic [71:0]             out_data_q;
  logic [1:0]              out_user_q;

  logic                    we;
  logic [AW-1:0]           waddr, raddr;
  logic [EW-1:0]           wdata, rdata;
  logic [KEY_BITS-1:0]     rd_key;
  logic [PAYLOAD_BITS-1:0] rd_pay;
  skq_pkg::cmp_t           cmp;
  logic [CW:0]             idx_inc;

  assign rd_key  = rdata[KEY_BITS-1:0];
  assign rd_pay  = rdata[EW-1:KEY_BITS];
  assign idx_inc = {1'b0, idx_q} + 1'b1;

  skq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  skq_cmp #(.KEY_BITS(KEY_BITS)) u_cmp (
    .a_i     (rd_key),
    .b_i     (key_q),
    .signed_i(signed_q),
    .res_o   (cmp)
  );

  always_comb begin
    we    = 1'b0;
    waddr = AW'(idx_q);
    wdata = rdata;
    raddr = AW'(idx_q);
    case (state_q)
      ST_SHIFT_RD: raddr = AW'(idx_q - 1'b1);
      ST_SHIFT_WR: we = 1'b1;
      ST_PUT: begin
        we    = 1'b1;
        waddr = AW'(at_q);
        wdata = {pay_q, key_q};
      end
      ST_DEL_RD:   raddr = AW'(idx_inc);
      ST_DEL_WR:   we = 1'b1;
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      signed_q    <= 1'b0;
      cnt_q       <= '0;
      idx_q       <= '0;
      at_q        <= '0;
      op_q        <= '0;
      rem_q       <= 1'b0;
      key_q       <= '0;
      pay_q       <= '0;
      res_key_q   <= '0;
      res_pay_q   <= '0;
      res_found_q <= 1'b0;
      res_rej_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_user_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        signed_q <= cfg_wdata_i;
      end
      if (out_valid_q && m_axis_tready && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            op_q        <= s_axis_tuser[2:0];
            rem_q       <= s_axis_tuser[3];
            key_q       <= KEY_BITS'(s_axis_tdata[31:0]);
            pay_q       <= PAYLOAD_BITS'(s_axis_tdata[63:32]);
            res_found_q <= 1'b0;
            res_rej_q   <= 1'b0;
            res_key_q   <= '0;
            res_pay_q   <= '0;
            idx_q       <= '0;
            case (skq_pkg::op_e'(s_axis_tuser[2:0]))
              skq_pkg::OP_INSERT: begin
                if (cnt_q == CW'(CAPACITY)) begin
                  res_rej_q <= 1'b1;
                  state_q   <= ST_DONE;
                end else begin
                  state_q <= ST_SCAN_RD;
                end
              end
              skq_pkg::OP_FIND_EQ, skq_pkg::OP_FIND_LT, skq_pkg::OP_FIND_GT:
                state_q <= ST_SCAN_RD;
              skq_pkg::OP_BY_POS: begin
                if (MW'(s_axis_tdata[67:64]) < MW'(cnt_q)) begin
                  idx_q   <= CW'(s_axis_tdata[67:64]);
                  state_q <= ST_FETCH_RD;
                end else begin
                  state_q <= ST_DONE;
                end
              end
              default: state_q <= ST_DONE;
            endcase
          end
        end
        ST_SCAN_RD: begin
          if (idx_q == cnt_q) begin
            if (op_q == skq_pkg::OP_INSERT) begin
              at_q    <= idx_q;
              state_q <= ST_SHIFT_RD;
            end else begin
              state_q <= ST_DONE;
            end
          end else begin
            state_q <= ST_SCAN_CK;
          end
        end
        ST_SCAN_CK: begin
          if (op_q == skq_pkg::OP_INSERT) begin
            if (cmp.lt) begin
              idx_q   <= CW'(idx_inc);
              state_q <= ST_SCAN_RD;
            end else begin
              at_q    <= idx_q;
              idx_q   <= cnt_q;
              state_q <= ST_SHIFT_RD;
            end
          end else if ((op_q == skq_pkg::OP_FIND_EQ && cmp.eq) ||
                       (op_q == skq_pkg::OP_FIND_LT && cmp.lt) ||
                       (op_q == skq_pkg::OP_FIND_GT && cmp.gt)) begin
            res_found_q <= 1'b1;
            res_key_q   <= rd_key;
            res_pay_q   <= rd_pay;
            state_q     <= rem_q ? ST_DEL_RD : ST_DONE;
          end else if (op_q == skq_pkg::OP_FIND_EQ && cmp.gt) begin
            state_q <= ST_DONE;
          end else begin
            idx_q   <= CW'(idx_inc);
            state_q <= ST_SCAN_RD;
          end
        end
        ST_SHIFT_RD: state_q <= (idx_q == at_q) ? ST_PUT : ST_SHIFT_WR;
        ST_SHIFT_WR: begin
          idx_q   <= idx_q - 1'b1;
          state_q <= ST_SHIFT_RD;
        end
        ST_PUT: begin
          cnt_q       <= cnt_q + 1'b1;
          res_found_q <= 1'b1;
          res_key_q   <= key_q;
          res_pay_q   <= pay_q;
          state_q     <= ST_DONE;
        end
        ST_FETCH_RD: state_q <= ST_FETCH_CK;
        ST_FETCH_CK: begin
          res_found_q <= 1'b1;
          res_key_q   <= rd_key;
          res_pay_q   <= rd_pay;
          state_q     <= rem_q ? ST_DEL_RD : ST_DONE;
        end
        ST_DEL_RD: begin
          if (idx_inc >= {1'b0, cnt_q}) begin
            cnt_q   <= cnt_q - 1'b1;
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_DEL_WR;
          end
        end
        ST_DEL_WR: begin
          idx_q   <= CW'(idx_inc);
          state_q <= ST_DEL_RD;
        end
        ST_DONE: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {3'b000, 5'(cnt_q), 32'(res_pay_q), 32'(res_key_q)};
            out_user_q  <= {res_rej_q, res_found_q};
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/skq_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module skq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ rtl/skq_cmp.sv @@
// Key comparator, unsigned or two's complement.
// Uses skq_pkg::cmp_t.
`default_nettype none
module skq_cmp #(
  parameter int KEY_BITS = 32
) (
  input  wire logic [KEY_BITS-1:0] a_i,
  input  wire logic [KEY_BITS-1:0] b_i,
  input  wire logic                signed_i,
  output skq_pkg::cmp_t            res_o
);

  logic [KEY_BITS-1:0] a, b;

  always_comb begin
    a = a_i;
    b = b_i;
    a[KEY_BITS-1] = a_i[KEY_BITS-1] ^ signed_i;
    b[KEY_BITS-1] = b_i[KEY_BITS-1] ^ signed_i;
    res_o.lt = a < b;
    res_o.eq = a == b;
    res_o.gt = a > b;
  end

endmodule
`default_nettype wire
